[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, checked also while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/bth_pkg.sv]
// ---------------------------------------------------------------------------
// bth_pkg
// Shared constants of the boundary tag heap allocator.
// ---------------------------------------------------------------------------
package bth_pkg;

  localparam int unsigned ArenaBytesDef    = 65536;
  localparam int unsigned BlockOverheadDef = 41;
  localparam int unsigned HeaderBytesDef   = 33;
  localparam int unsigned MaxBlocksDef     = 256;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoFit    = 3'd1;
  localparam logic [2:0] StOutArena = 3'd2;
  localparam logic [2:0] StNotStart = 3'd3;
  localparam logic [2:0] StIsFree   = 3'd4;

  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitBest  = 2'd1;
  localparam logic [1:0] FitWorst = 2'd2;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

endpackage

[hw/rtl/bth_ram.sv]
// ---------------------------------------------------------------------------
// bth_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bth_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/boundary_tag_heap_allocator.sv]
// ---------------------------------------------------------------------------
// boundary_tag_heap_allocator
// Boundary-tag heap allocator over one byte arena, slot table in RAM.
// ---------------------------------------------------------------------------
// Allocate walks the block chain one slot at a time, at most MaxBlocks slots,
// with one RAM read per slot (S_WRD, then S_WCHK), then scans the slot table for
// an empty slot used by a split; a free scans the slot table one entry at a time
// to find the block start, then rewrites the neighbours.
// busy is high for the whole operation; the result appears for one cycle on
// done_o and cannot be held off. After reset a clearing pass writes every
// table entry; start is ignored until it ends.
module boundary_tag_heap_allocator #(
  parameter int unsigned ArenaBytes    = bth_pkg::ArenaBytesDef,
  parameter int unsigned BlockOverhead = bth_pkg::BlockOverheadDef,
  parameter int unsigned HeaderBytes   = bth_pkg::HeaderBytesDef,
  parameter int unsigned MaxBlocks     = bth_pkg::MaxBlocksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        command_i,
  input  logic [15:0] element_size_i,
  input  logic [15:0] element_count_i,
  input  logic [15:0] free_offset_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [15:0] user_offset_o,
  output logic [15:0] granted_bytes_o
);
  import bth_pkg::*;

  localparam int unsigned IdxW  = $clog2(MaxBlocks);
  localparam int unsigned LinkW = IdxW + 1;
  localparam int unsigned AW    = 17;
  localparam int unsigned EntW  = AW + AW + 1 + 1 + LinkW + LinkW;
  localparam logic [LinkW-1:0] LinkNull = LinkW'(MaxBlocks);
  localparam logic [AW-1:0] Ovh  = AW'(BlockOverhead);
  localparam logic [AW-1:0] Hdr  = AW'(HeaderBytes);
  localparam logic [AW-1:0] Aren = AW'(ArenaBytes);

  typedef struct packed {
    logic [AW-1:0]    start;
    logic [AW-1:0]    size;
    logic             in_use;
    logic             valid;
    logic [LinkW-1:0] next;
    logic [LinkW-1:0] prev;
  } slot_t;

  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_WRD   = 14'b00000000000100,
    S_WCHK  = 14'b00000000001000,
    S_TRD   = 14'b00000000010000,
    S_ERD   = 14'b00000000100000,
    S_ECHK  = 14'b00000001000000,
    S_SPLIT = 14'b00000010000000,
    S_NXRD  = 14'b00000100000000,
    S_FRD   = 14'b00001000000000,
    S_FCHK  = 14'b00010000000000,
    S_FNX   = 14'b00100000000000,
    S_FPV   = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0]       fit_q;
  logic [IdxW-1:0]  clr_q, clr_d;
  logic [32:0]      req_q, req_d;
  logic [AW-1:0]    blk_q, blk_d;
  logic [LinkW-1:0] cur_q, cur_d, tgt_q, tgt_d, ns_q, ns_d;
  logic [IdxW:0]    steps_q, steps_d;
  slot_t            tgt_e_q, tgt_e_d, aux_q, aux_d;
  logic             done_q, done_d;
  logic [2:0]       st_q, st_d;
  logic [15:0]      uo_q, uo_d, gb_q, gb_d;
  logic [1:0]       sub_q, sub_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  slot_t           wdata, rdata;
  logic [EntW-1:0] rraw;

  bth_ram #(.Width(EntW), .Depth(MaxBlocks)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rraw)
  );
  assign rdata = slot_t'(rraw);

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = st_q;
  assign user_offset_o   = uo_q;
  assign granted_bytes_o = gb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      fit_q   <= FitFirst;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        fit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    blk_q   <= blk_d;
    cur_q   <= cur_d;
    tgt_q   <= tgt_d;
    ns_q    <= ns_d;
    steps_q <= steps_d;
    tgt_e_q <= tgt_e_d;
    aux_q   <= aux_d;
    st_q    <= st_d;
    uo_q    <= uo_d;
    gb_q    <= gb_d;
    sub_q   <= sub_d;
  end

  logic          better;
  logic [AW-1:0] rest;
  logic [32:0]   rsize;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    req_d   = req_q;
    blk_d   = blk_q;
    cur_d   = cur_q;
    tgt_d   = tgt_q;
    ns_d    = ns_q;
    steps_d = steps_q;
    tgt_e_d = tgt_e_q;
    aux_d   = aux_q;
    st_d    = st_q;
    uo_d    = uo_q;
    gb_d    = gb_q;
    sub_d   = sub_q;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = cur_q[IdxW-1:0];
    wdata   = '0;
    raddr   = cur_q[IdxW-1:0];
    rsize   = {16'd0, rdata.size};
    better  = 1'b0;
    rest    = tgt_e_q.size - req_q[AW-1:0];

    unique case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        wdata.next = LinkNull;
        wdata.prev = LinkNull;
        if (clr_q == '0) begin
          wdata.valid = 1'b1;
          wdata.size  = Aren - Ovh;
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == IdxW'(MaxBlocks - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_d   = {1'b0, 32'(element_size_i) * 32'(element_count_i)};
          blk_d   = {1'b0, free_offset_i} - Hdr;
          cur_d   = '0;
          tgt_d   = LinkNull;
          steps_d = '0;
          st_d    = StOk;
          uo_d    = '0;
          gb_d    = '0;
          if (command_i == CmdAlloc) begin
            state_d = S_WRD;
          end else if ({1'b0, free_offset_i} < Hdr ||
                       ({1'b0, free_offset_i} - Hdr) >= Aren) begin
            st_d    = StOutArena;
            state_d = S_FIN;
          end else begin
            state_d = S_FRD;
          end
        end
      end
      // chain walk: read issued, data next cycle
      S_WRD: begin
        state_d = S_WCHK;
      end
      S_WCHK: begin
        if (rdata.valid && !rdata.in_use && rsize >= req_q) begin
          unique case (fit_q)
            FitFirst: better = 1'b1;
            FitBest:  better = (tgt_q == LinkNull) || (rdata.size < tgt_e_q.size);
            FitWorst: better = (tgt_q == LinkNull) || (rdata.size > tgt_e_q.size);
            default:  better = 1'b0;
          endcase
        end
        if (better) begin
          tgt_d   = cur_q;
          tgt_e_d = rdata;
        end
        steps_d = steps_q + 1'b1;
        cur_d   = rdata.next;
        if ((better && fit_q == FitFirst) || rdata.next == LinkNull ||
            steps_q == (IdxW+1)'(MaxBlocks - 1)) begin
          cur_d = '0;
          if (!better && tgt_q == LinkNull) begin
            st_d    = StNoFit;
            state_d = S_FIN;
          end else begin
            ns_d    = LinkNull;
            state_d = S_ERD;
          end
        end else begin
          state_d = S_WRD;
        end
      end
      // empty-slot scan
      S_ERD: begin
        state_d = S_ECHK;
      end
      S_ECHK: begin
        if (!rdata.valid) begin
          ns_d    = cur_q;
          state_d = S_SPLIT;
        end else if (cur_q == LinkW'(MaxBlocks - 1)) begin
          state_d = S_SPLIT;
        end else begin
          cur_d   = cur_q + 1'b1;
          state_d = S_ERD;
        end
        sub_d = 2'd0;
      end
      S_SPLIT: begin
        if (rest >= Ovh && ns_q != LinkNull && req_q[32:AW] == '0) begin
          unique case (sub_q)
            2'd0: begin
              we          = 1'b1;
              waddr       = ns_q[IdxW-1:0];
              wdata.start = tgt_e_q.start + Ovh + req_q[AW-1:0];
              wdata.size  = rest - Ovh;
              wdata.valid = 1'b1;
              wdata.next  = tgt_e_q.next;
              wdata.prev  = tgt_q;
              sub_d       = 2'd1;
              if (tgt_e_q.next != LinkNull) begin
                raddr   = tgt_e_q.next[IdxW-1:0];
                state_d = S_NXRD;
              end
            end
            default: begin
              we         = 1'b1;
              waddr      = tgt_q[IdxW-1:0];
              wdata      = tgt_e_q;
              wdata.size = req_q[AW-1:0];
              wdata.in_use = 1'b1;
              wdata.next = ns_q;
              st_d       = StOk;
              uo_d       = 16'(tgt_e_q.start + Hdr);
              gb_d       = 16'(req_q);
              state_d    = S_FIN;
            end
          endcase
        end else begin
          we           = 1'b1;
          waddr        = tgt_q[IdxW-1:0];
          wdata        = tgt_e_q;
          wdata.in_use = 1'b1;
          st_d         = StOk;
          uo_d         = 16'(tgt_e_q.start + Hdr);
          gb_d         = 16'(tgt_e_q.size);
          state_d      = S_FIN;
        end
      end
      S_NXRD: begin
        // rdata holds old next; relink its prev to the new slot
        we         = 1'b1;
        waddr      = tgt_e_q.next[IdxW-1:0];
        wdata      = rdata;
        wdata.prev = ns_q;
        state_d    = S_SPLIT;
      end
      // free: scan slots for a matching start
      S_FRD: begin
        sub_d   = 2'd0;
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (rdata.valid && rdata.start == blk_q) begin
          tgt_d   = cur_q;
          tgt_e_d = rdata;
          if (!rdata.in_use) begin
            st_d    = StIsFree;
            state_d = S_FIN;
          end else begin
            tgt_e_d.in_use = 1'b0;
            raddr   = rdata.next[IdxW-1:0];
            state_d = S_FNX;
          end
        end else if (cur_q == LinkW'(MaxBlocks - 1)) begin
          st_d    = StNotStart;
          state_d = S_FIN;
        end else begin
          cur_d   = cur_q + 1'b1;
          raddr   = cur_d[IdxW-1:0];
          state_d = S_FRD;
        end
      end
      // sub 0: wait; sub 1: merge with next, request its next; sub 2: wait; sub 3: relink that slot's prev
      S_FNX: begin
        raddr = tgt_e_q.next[IdxW-1:0];
        if (sub_q == 2'd0) begin
          sub_d = 2'd1;
        end else if (sub_q == 2'd1) begin
          aux_d = rdata;
          if (tgt_e_q.next != LinkNull && rdata.valid && !rdata.in_use) begin
            we    = 1'b1;
            waddr = tgt_e_q.next[IdxW-1:0];
            wdata = '0;
            wdata.next = LinkNull;
            wdata.prev = LinkNull;
            tgt_e_d.size = tgt_e_q.size + Ovh + rdata.size;
            tgt_e_d.next = rdata.next;
            if (rdata.next != LinkNull) begin
              raddr = rdata.next[IdxW-1:0];
              sub_d = 2'd2;
            end else begin
              sub_d = 2'd3;
            end
          end else begin
            sub_d = 2'd3;
          end
        end else if (sub_q == 2'd2) begin
          sub_d = 2'd3;
          raddr = tgt_e_q.next[IdxW-1:0];
        end else begin
          if (aux_q.valid && tgt_e_q.next == aux_q.next && aux_q.next != LinkNull &&
              !(aux_q.in_use)) begin
            we         = 1'b1;
            waddr      = aux_q.next[IdxW-1:0];
            wdata      = rdata;
            wdata.prev = tgt_q;
          end
          raddr   = tgt_e_q.prev[IdxW-1:0];
          sub_d   = 2'd0;
          state_d = S_FPV;
        end
      end
      S_FPV: begin
        raddr = tgt_e_q.prev[IdxW-1:0];
        if (sub_q == 2'd0) begin
          sub_d = 2'd1;
        end else if (sub_q == 2'd1) begin
          if (tgt_e_q.prev != LinkNull && rdata.valid && !rdata.in_use) begin
            we         = 1'b1;
            waddr      = tgt_e_q.prev[IdxW-1:0];
            wdata      = rdata;
            wdata.size = rdata.size + Ovh + tgt_e_q.size;
            wdata.next = tgt_e_q.next;
            aux_d      = rdata;
            sub_d      = 2'd2;
          end else begin
            we      = 1'b1;
            waddr   = tgt_q[IdxW-1:0];
            wdata   = tgt_e_q;
            state_d = S_FIN;
          end
        end else if (sub_q == 2'd2) begin
          we    = 1'b1;
          waddr = tgt_q[IdxW-1:0];
          wdata = '0;
          wdata.next = LinkNull;
          wdata.prev = LinkNull;
          raddr = tgt_e_q.next[IdxW-1:0];
          if (tgt_e_q.next != LinkNull) begin
            sub_d = 2'd3;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          we         = 1'b1;
          waddr      = tgt_e_q.next[IdxW-1:0];
          wdata      = rdata;
          wdata.prev = tgt_e_q.prev;
          state_d    = S_FIN;
        end
      end
      S_FIN: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_CLR;
    endcase
  end

endmodule

[hw/rtl/bth_checker.sv]
// ---------------------------------------------------------------------------
// bth_checker
// Port-level checks of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bth_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [15:0] user_offset_o,
  input logic [15:0] granted_bytes_o
);
  import bth_pkg::*;

  `ASSERT_IMPL(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accept not busy")
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o |-> !busy, "done while busy")
  `ASSERT_IMPL(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "done held")
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, (done_o && status_o != StOk) |-> (user_offset_o == 16'd0 && granted_bytes_o == 16'd0), "nonzero on error")
  `ASSERT_IMPL(a_status_rng, clk_i, rst_ni, done_o |-> (status_o <= StIsFree), "bad status")

endmodule

bind boundary_tag_heap_allocator bth_checker u_bth_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .status_o       (status_o),
  .user_offset_o  (user_offset_o),
  .granted_bytes_o(granted_bytes_o)
);

[tb/boundary_tag_heap_allocator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_test
// Self-checking bench: directed table then random allocate/free traffic under
// every fit policy, each beat checked against its typed row or an in-bench heap model.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator_test;
  import bth_pkg::*;

  localparam int unsigned ArenaB  = ArenaBytesDef;
  localparam int unsigned Ovh     = BlockOverheadDef;
  localparam int unsigned HdrB    = HeaderBytesDef;
  localparam int unsigned NBlk    = MaxBlocksDef;
  localparam int unsigned LinkNil = NBlk;
  localparam logic [1:0]  FitNone = 2'd3;
  localparam int unsigned Settle  = 4 * NBlk + 64;
  localparam longint      CycLimit = 20_000_000;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] uoff;
    logic [15:0] gbytes;
  } beat_t;

  typedef struct {
    logic        cmd;
    logic [15:0] esz;
    logic [15:0] ecnt;
    logic [15:0] off;
    bit          typed;
    beat_t       exp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_wdata_i = '0;
  logic        command_i = 1'b0;
  logic [15:0] element_size_i = '0;
  logic [15:0] element_count_i = '0;
  logic [15:0] free_offset_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [15:0] user_offset_o;
  logic [15:0] granted_bytes_o;

  boundary_tag_heap_allocator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_i      (command_i),
    .element_size_i (element_size_i),
    .element_count_i(element_count_i),
    .free_offset_i  (free_offset_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .user_offset_o  (user_offset_o),
    .granted_bytes_o(granted_bytes_o)
  );

  always #5 clk_i = ~clk_i;

  // heap model state
  int unsigned blk_start [NBlk];
  int unsigned blk_size  [NBlk];
  bit          blk_used  [NBlk];
  int unsigned blk_next  [NBlk];
  int unsigned blk_prev  [NBlk];
  bit          blk_live  [NBlk];
  logic [1:0]  policy;

  beat_t       pending_beats[$];
  int unsigned live_offsets[$];
  row_t        dir_rows[$];
  int          mismatches = 0;
  bit          failed = 0;
  longint      cycles = 0;

  function automatic void heap_init();
    for (int i = 0; i < NBlk; i++) begin
      blk_start[i] = 0; blk_size[i] = 0; blk_used[i] = 0;
      blk_next[i] = LinkNil; blk_prev[i] = LinkNil; blk_live[i] = 0;
    end
    blk_live[0] = 1;
    blk_size[0] = ArenaB - Ovh;
    policy = FitFirst;
  endfunction

  function automatic void merge_into(int unsigned p, int unsigned s);
    int unsigned n;
    n = blk_next[s];
    blk_size[p] = blk_size[p] + Ovh + blk_size[s];
    blk_next[p] = n;
    if (n < NBlk) blk_prev[n] = p;
    blk_live[s] = 0;
    blk_used[s] = 0;
  endfunction

  function automatic beat_t heap_alloc(int unsigned req);
    beat_t r;
    int unsigned cur, target, steps, rest, ns, n;
    r = '{StOk, 16'd0, 16'd0};
    cur = 0; target = LinkNil; steps = 0;
    while (cur < NBlk && steps < NBlk) begin
      if (blk_live[cur] && !blk_used[cur] && blk_size[cur] >= req) begin
        if (policy == FitFirst) begin
          target = cur;
          break;
        end else if (policy == FitBest) begin
          if (target >= NBlk || blk_size[cur] < blk_size[target]) target = cur;
        end else if (policy == FitWorst) begin
          if (target >= NBlk || blk_size[cur] > blk_size[target]) target = cur;
        end
      end
      cur = blk_next[cur];
      steps++;
    end
    if (target >= NBlk) begin
      r.status = StNoFit;
      return r;
    end
    rest = blk_size[target] - req;
    ns = LinkNil;
    for (int i = 0; i < NBlk; i++)
      if (!blk_live[i]) begin
        ns = i;
        break;
      end
    if (rest >= Ovh && ns < NBlk) begin
      n = blk_next[target];
      blk_size[target] = req;
      blk_start[ns] = blk_start[target] + Ovh + req;
      blk_size[ns] = rest - Ovh;
      blk_used[ns] = 0;
      blk_live[ns] = 1;
      blk_next[ns] = n;
      blk_prev[ns] = target;
      if (n < NBlk) blk_prev[n] = ns;
      blk_next[target] = ns;
    end
    blk_used[target] = 1;
    r.uoff = 16'(blk_start[target] + HdrB);
    r.gbytes = 16'(blk_size[target]);
    return r;
  endfunction

  function automatic beat_t heap_free(int unsigned uoff);
    beat_t r;
    int unsigned blk, hit, p, n;
    r = '{StOk, 16'd0, 16'd0};
    hit = LinkNil;
    if (uoff < HdrB) begin
      r.status = StOutArena;
      return r;
    end
    blk = uoff - HdrB;
    if (blk >= ArenaB) begin
      r.status = StOutArena;
      return r;
    end
    for (int s = 0; s < NBlk; s++)
      if (blk_live[s] && blk_start[s] == blk) begin
        hit = s;
        break;
      end
    if (hit >= NBlk) begin
      r.status = StNotStart;
      return r;
    end
    if (!blk_used[hit]) begin
      r.status = StIsFree;
      return r;
    end
    blk_used[hit] = 0;
    p = blk_prev[hit];
    n = blk_next[hit];
    if (n < NBlk && blk_live[n] && !blk_used[n]) merge_into(hit, n);
    if (p < NBlk && blk_live[p] && !blk_used[p]) merge_into(p, hit);
    return r;
  endfunction

  // one beat: drive, wait for acceptance, predict
  task automatic send_beat(row_t it);
    beat_t r;
    start <= 1'b1;
    command_i <= it.cmd;
    element_size_i <= it.esz;
    element_count_i <= it.ecnt;
    free_offset_i <= it.off;
    do @(posedge clk_i); while (busy);
    if (it.cmd == CmdAlloc) r = heap_alloc(int'(it.esz) * int'(it.ecnt));
    else r = heap_free(it.off);
    if (r.status == StOk) begin
      if (it.cmd == CmdAlloc) live_offsets.push_back(r.uoff);
      else
        foreach (live_offsets[i])
          if (live_offsets[i] == it.off) begin
            live_offsets.delete(i);
            break;
          end
    end
    pending_beats.push_back(it.typed ? it.exp : r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic set_policy(logic [1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    policy = v;
  endtask

  task automatic add_row(logic cmd, logic [15:0] esz, logic [15:0] ecnt, logic [15:0] off,
                         bit typed, logic [2:0] st, logic [15:0] uo, logic [15:0] gb);
    row_t r;
    r = '{cmd, esz, ecnt, off, typed, '{st, uo, gb}};
    dir_rows.push_back(r);
  endtask

  function automatic row_t random_item();
    row_t it;
    int unsigned k;
    it = '{CmdAlloc, 16'd0, 16'd0, 16'($urandom), 0, '{StOk, 16'd0, 16'd0}};
    k = $urandom_range(0, 99);
    if (k < 45) begin
      it.esz = 16'($urandom_range(1, 64));
      it.ecnt = 16'($urandom_range(0, 8));
    end else if (k < 52) begin
      it.esz = 16'($urandom);
      it.ecnt = 16'($urandom_range(0, 1));
    end else if (k < 55) begin
      it.esz = 16'($urandom);
      it.ecnt = 16'($urandom);
    end else if (k < 88 && live_offsets.size() != 0) begin
      it.cmd = CmdFree;
      it.off = 16'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
    end else begin
      it.cmd = CmdFree;
      // half the time in 0..200, otherwise anywhere
      if ($urandom_range(0, 1)) it.off = 16'($urandom_range(0, 200));
    end
    it.esz = (it.cmd == CmdFree) ? 16'($urandom) : it.esz;
    it.ecnt = (it.cmd == CmdFree) ? 16'($urandom) : it.ecnt;
    return it;
  endfunction

  // result checker: receiver never stalls
  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && done_o) begin
      if (pending_beats.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: status %0d", status_o);
      end else begin
        e = pending_beats.pop_front();
        if (status_o !== e.status || user_offset_o !== e.uoff ||
            granted_bytes_o !== e.gbytes) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d off=%0d bytes=%0d got st=%0d off=%0d bytes=%0d",
                     e.status, e.uoff, e.gbytes, status_o, user_offset_o, granted_bytes_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [1:0]  ph_policy [6];
    int unsigned ph_idle   [6];
    int unsigned ph_items  [6];
    row_t        it;
    heap_init();
    ph_policy = '{FitFirst, FitBest, FitWorst, FitNone, FitFirst, FitWorst};
    ph_idle   = '{0, 58, 7, 58, 0, 7};
    ph_items  = '{250, 250, 200, 60, 170, 170};

    // directed rows; offsets follow from the reset chain under first fit
    add_row(CmdAlloc, 16'd0, 16'd0, 16'd0, 1, StOk, 16'd33, 16'd0);      // empty request
    add_row(CmdFree, 16'd0, 16'd0, 16'd0, 1, StOutArena, 16'd0, 16'd0);
    add_row(CmdFree, 16'd0, 16'd0, 16'd32, 1, StOutArena, 16'd0, 16'd0);
    add_row(CmdFree, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, StNotStart, 16'd0, 16'd0);
    add_row(CmdFree, 16'd0, 16'd0, 16'd33, 1, StOk, 16'd0, 16'd0);
    add_row(CmdFree, 16'd0, 16'd0, 16'd33, 1, StIsFree, 16'd0, 16'd0);
    add_row(CmdAlloc, 16'hFFFF, 16'hFFFF, 16'd0, 1, StNoFit, 16'd0, 16'd0);
    add_row(CmdAlloc, 16'hFFFF, 16'd1, 16'd0, 1, StNoFit, 16'd0, 16'd0);
    add_row(CmdAlloc, 16'd1, 16'd65495, 16'd0, 1, StOk, 16'd33, 16'd65495);
    add_row(CmdAlloc, 16'd1, 16'd0, 16'd0, 1, StNoFit, 16'd0, 16'd0);
    add_row(CmdFree, 16'd0, 16'd0, 16'd33, 1, StOk, 16'd0, 16'd0);
    add_row(CmdAlloc, 16'd10, 16'd10, 16'd0, 0, StOk, 16'd0, 16'd0);
    add_row(CmdAlloc, 16'd1, 16'd65000, 16'd0, 0, StOk, 16'd0, 16'd0);   // rest large enough to split
    add_row(CmdAlloc, 16'd3, 16'd7, 16'd0, 0, StOk, 16'd0, 16'd0);
    add_row(CmdFree, 16'd0, 16'd0, 16'd174, 0, StOk, 16'd0, 16'd0);
    add_row(CmdFree, 16'd0, 16'd0, 16'd134, 0, StOk, 16'd0, 16'd0);
    add_row(CmdFree, 16'd0, 16'd0, 16'd33, 0, StOk, 16'd0, 16'd0);
    add_row(CmdAlloc, 16'h8000, 16'd1, 16'd0, 0, StOk, 16'd0, 16'd0);
    add_row(CmdFree, 16'hAAAA, 16'h5555, 16'h5555, 0, StOk, 16'd0, 16'd0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (Settle) @(posedge clk_i);
    while (busy) @(posedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i]);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_policy(ph_policy[ph]);
      for (int n = 0; n < ph_items[ph]; n++) begin
        it = random_item();
        send_beat(it);
        if (n == ph_items[ph] / 2 && ph == 1) begin
          // hold off until every outstanding beat has returned
          start <= 1'b0;
          while (pending_beats.size() != 0) @(posedge clk_i);
        end else if ($urandom_range(0, 99) < ph_idle[ph]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
      drain();
    end

    if (failed || pending_beats.size() != 0) begin
      $display("RESULT: ERROR");
    end else begin
      $display("RESULT: OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/bth_pkg.sv
hw/rtl/bth_ram.sv
hw/rtl/boundary_tag_heap_allocator.sv
hw/rtl/bth_checker.sv
tb/boundary_tag_heap_allocator_test.sv
